[rtl/core/jsd_pkg.sv]
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types and constants for the scaled radial deadzone pipeline.
// ----------------------------------------------------------------------------
package jsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int DZ_BITS     = 15;
  localparam int SQRT_STEPS  = 16;
  localparam int DIV1_STEPS  = 16;
  localparam int DIV2_STEPS  = 17;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_RADIAL = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One request in flight; each cell advances its own step fields.
  typedef struct packed {
    logic                 vld;
    logic                 mode;
    logic                 neg;
    logic [14:0]          apos;
    logic [DZ_BITS-1:0]   dz;
    logic [16:0]          ua;
    logic [31:0]          sq;
    logic [15:0]          root;
    logic [17:0]          srem;
    logic                 zero;
    logic                 ovf;
    logic [15:0]          drem;
    logic [16:0]          dlow;
    logic [15:0]          dvs;
  } item_t;

endpackage

[rtl/core/jsd_in_if.sv]
// ----------------------------------------------------------------------------
// jsd_in_if
// Sample request channel.
// ----------------------------------------------------------------------------
interface jsd_in_if;
  logic                valid;
  logic                ready;
  logic                mode;
  logic signed [15:0]  axis_sample;
  logic signed [15:0]  partner_sample;

  modport source (output valid, mode, axis_sample, partner_sample, input ready);
  modport sink   (input valid, mode, axis_sample, partner_sample, output ready);
endinterface

[rtl/core/jsd_out_if.sv]
// ----------------------------------------------------------------------------
// jsd_out_if
// Shaped result channel.
// ----------------------------------------------------------------------------
interface jsd_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  shaped_value;
  logic                clipped;

  modport source (output valid, shaped_value, clipped, input ready);
  modport sink   (input valid, shaped_value, clipped, output ready);
endinterface

[rtl/core/joystick_scaled_deadzone_top.sv]
// ----------------------------------------------------------------------------
// joystick_scaled_deadzone_top
// Deadzone removal and rescaling for one stick or trigger axis.
//
//   channel  dir  handshake        payload
//   in_if    in   valid/ready      mode, axis_sample, partner_sample
//   out_if   out  valid/ready      shaped_value, clipped
//   cfg      in   cfg_we           cfg_wdata (deadzone, 15 bits)
//
// One request per cycle while the output is not held. Stages: input stage,
// 16 square-root cells, scale stage, 16 divide cells, normalize stage, 17
// divide cells, output register. The whole cell row advances together and
// holds while a result waits at output; reset clears valid bits and deadzone.
// ----------------------------------------------------------------------------
module joystick_scaled_deadzone_top (
  input  logic                          clk,
  input  logic                          rst_n,
  jsd_in_if.sink                        in_if,
  jsd_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [jsd_pkg::DZ_BITS-1:0]   cfg_wdata
);
  import jsd_pkg::*;

  logic [DZ_BITS-1:0] deadzone_r;
  logic               en;

  item_t front_r, front_nxt;
  item_t mid_r,   mid_nxt;
  item_t nrm_r,   nrm_nxt;
  item_t sq_p   [SQRT_STEPS+1];
  item_t d1_p   [DIV1_STEPS+1];
  item_t d2_p   [DIV2_STEPS+1];

  logic               out_vld_r;
  logic signed [15:0] out_val_r, out_val_nxt;
  logic               out_clip_r, out_clip_nxt;

  logic [16:0] ub;
  logic [32:0] prod;
  logic [15:0] udiv;
  logic [15:0] den;
  logic [14:0] lin_d;
  logic        lin_zero;
  logic [16:0] v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= '0;
    end else if (cfg_we) begin
      deadzone_r <= cfg_wdata;
    end
  end

  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  // input stage: magnitudes and sum of squares
  always_comb begin
    front_nxt      = '0;
    front_nxt.vld  = in_if.valid;
    front_nxt.mode = in_if.mode;
    front_nxt.neg  = in_if.axis_sample[15];
    front_nxt.apos = in_if.axis_sample[14:0];
    front_nxt.dz   = deadzone_r;
    front_nxt.ua   = in_if.axis_sample[15] ? 17'(~{1'b1, in_if.axis_sample}) + 17'd1
                                           : {1'b0, in_if.axis_sample};
    ub             = in_if.partner_sample[15] ? 17'(~{1'b1, in_if.partner_sample}) + 17'd1
                                              : {1'b0, in_if.partner_sample};
    front_nxt.sq   = 32'(front_nxt.ua * front_nxt.ua) + 32'(ub * ub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (en) begin
      front_r <= front_nxt;
    end
  end

  assign sq_p[0] = front_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    jsd_sqrt_cell u_cell (.clk, .rst_n, .en, .d_i(sq_p[i]), .q_o(sq_p[i+1]));
  end

  // scale stage: |a| * (mag - dz), then divide by mag
  always_comb begin
    mid_nxt      = sq_p[SQRT_STEPS];
    mid_nxt.zero = !(sq_p[SQRT_STEPS].root > {1'b0, sq_p[SQRT_STEPS].dz});
    prod         = 33'(sq_p[SQRT_STEPS].ua * 16'(sq_p[SQRT_STEPS].root
                                               - {1'b0, sq_p[SQRT_STEPS].dz}));
    mid_nxt.drem = {1'b0, prod[30:16]};
    mid_nxt.dlow = {prod[15:0], 1'b0};
    mid_nxt.dvs  = sq_p[SQRT_STEPS].root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.vld <= 1'b0;
    end else if (en) begin
      mid_r <= mid_nxt;
    end
  end

  assign d1_p[0] = mid_r;

  for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
    jsd_div_cell u_cell (.clk, .rst_n, .en, .d_i(d1_p[i]), .q_o(d1_p[i+1]));
  end

  // normalize stage: divide by (1 - dz)
  always_comb begin
    nrm_nxt  = d1_p[DIV1_STEPS];
    den      = 16'(17'd32768 - {2'b00, d1_p[DIV1_STEPS].dz});
    lin_zero = d1_p[DIV1_STEPS].neg || !(d1_p[DIV1_STEPS].apos > d1_p[DIV1_STEPS].dz);
    lin_d    = 15'(d1_p[DIV1_STEPS].apos - d1_p[DIV1_STEPS].dz);
    if (d1_p[DIV1_STEPS].mode == MODE_RADIAL) begin
      udiv        = d1_p[DIV1_STEPS].dlow[15:0];
      nrm_nxt.ovf = ({2'b00, udiv} >= {den, 2'b00});
    end else begin
      udiv         = {1'b0, lin_d};
      nrm_nxt.ovf  = 1'b0;
      nrm_nxt.zero = lin_zero;
    end
    nrm_nxt.drem = {2'b00, udiv[15:2]};
    nrm_nxt.dlow = {udiv[1:0], 15'd0};
    nrm_nxt.dvs  = den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r.vld <= 1'b0;
    end else if (en) begin
      nrm_r <= nrm_nxt;
    end
  end

  assign d2_p[0] = nrm_r;

  for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_div2
    jsd_div_cell u_cell (.clk, .rst_n, .en, .d_i(d2_p[i]), .q_o(d2_p[i+1]));
  end

  // sign and saturation
  always_comb begin
    v            = d2_p[DIV2_STEPS].dlow;
    out_val_nxt  = '0;
    out_clip_nxt = 1'b0;
    if (!d2_p[DIV2_STEPS].zero) begin
      if (!d2_p[DIV2_STEPS].neg) begin
        if (d2_p[DIV2_STEPS].ovf || v > 17'd32767) begin
          out_val_nxt  = 16'sh7fff;
          out_clip_nxt = 1'b1;
        end else begin
          out_val_nxt = signed'(v[15:0]);
        end
      end else begin
        if (d2_p[DIV2_STEPS].ovf || v > 17'd32768) begin
          out_val_nxt  = 16'sh8000;
          out_clip_nxt = 1'b1;
        end else begin
          out_val_nxt = signed'(16'(~v + 17'd1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= d2_p[DIV2_STEPS].vld;
      out_val_r  <= out_val_nxt;
      out_clip_r <= out_clip_nxt;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.shaped_value = out_val_r;
  assign out_if.clipped      = out_clip_r;

  a_clip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_clip_r |-> out_val_r != 16'sd0)
    else $error("clipped result is zero");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> front_r.vld)
    else $error("accepted request not captured");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("output valid after reset");

endmodule

[rtl/core/jsd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// jsd_sqrt_cell
// One restoring square-root step: retires two radicand bits per cell.
// ----------------------------------------------------------------------------
module jsd_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  jsd_pkg::item_t d_i,
  output jsd_pkg::item_t q_o
);
  import jsd_pkg::*;

  item_t       q_r;
  item_t       q_nxt;
  logic [19:0] trial;
  logic [19:0] tst;

  always_comb begin
    q_nxt = d_i;
    trial = {d_i.srem, d_i.sq[31:30]};
    tst   = {2'b00, d_i.root, 2'b01};
    q_nxt.sq = {d_i.sq[29:0], 2'b00};
    if (trial >= tst) begin
      q_nxt.srem = 18'(trial - tst);
      q_nxt.root = {d_i.root[14:0], 1'b1};
    end else begin
      q_nxt.srem = trial[17:0];
      q_nxt.root = {d_i.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;
endmodule

[rtl/core/jsd_div_cell.sv]
// ----------------------------------------------------------------------------
// jsd_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module jsd_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  jsd_pkg::item_t d_i,
  output jsd_pkg::item_t q_o
);
  import jsd_pkg::*;

  item_t       q_r;
  item_t       q_nxt;
  logic [16:0] trial;
  logic        qbit;

  always_comb begin
    q_nxt = d_i;
    trial = {d_i.drem, d_i.dlow[16]};
    qbit  = (trial >= {1'b0, d_i.dvs});
    if (qbit) begin
      q_nxt.drem = 16'(trial - {1'b0, d_i.dvs});
    end else begin
      q_nxt.drem = trial[15:0];
    end
    q_nxt.dlow = {d_i.dlow[15:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;
endmodule
